// ===== rtl/psbm_pkg.sv =====
// shared types and constants of the periodic sphere blocking mask
package psbm_pkg;

  localparam int MAX_GRID    = 1024;
  localparam int MAT_ENTRIES = 9;
  localparam int DIV_STEPS   = 42;
  localparam int FRAC_W      = 32;
  localparam int RAD_W       = 31;
  localparam int DIST_W      = 34;
  localparam int SQRT_STEPS  = 32;

  typedef enum logic [1:0] {
    OP_LOAD_SPHERE = 2'd0,
    OP_LOAD_MATRIX = 2'd1,
    OP_QUERY       = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_GRID_X  = 3'd0,
    REG_GRID_Y  = 3'd1,
    REG_GRID_Z  = 3'd2,
    REG_COUNT   = 3'd3,
    REG_GAIN    = 3'd4,
    REG_CEILING = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_DRAIN,
    ST_ENERGY,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [RAD_W-1:0]  radius;
    logic [FRAC_W-1:0] cz;
    logic [FRAC_W-1:0] cy;
    logic [FRAC_W-1:0] cx;
  } sphere_t;

  typedef logic [2:0][FRAC_W-1:0] frac3_t;
  typedef logic [MAT_ENTRIES-1:0][31:0] mat_t;

endpackage

// ===== rtl/psbm_frac_div.sv =====
// three restoring dividers forming index * 2^32 / grid, one quotient bit per cycle
module psbm_frac_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [2:0][9:0]      idx,
  input  logic [2:0][10:0]     grid,
  output logic                 done,
  output psbm_pkg::frac3_t     frac
);
  import psbm_pkg::*;

  logic              busy_r;
  logic [5:0]        step_r;
  logic              done_r;
  logic [2:0][41:0]  dvd_r;
  logic [2:0][10:0]  rem_r;
  logic [2:0][10:0]  div_r;
  frac3_t            q_r;
  logic [2:0][11:0]  sh;
  logic [2:0]        qb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = {rem_r[i], dvd_r[i][41]};
      qb[i] = (sh[i] >= {1'b0, div_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 6'd1;
        if (step_r == 6'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (start) begin
        dvd_r[i] <= {idx[i], 32'd0};
        rem_r[i] <= '0;
        div_r[i] <= grid[i];
      end else if (busy_r) begin
        dvd_r[i] <= {dvd_r[i][40:0], 1'b0};
        rem_r[i] <= qb[i] ? 11'(sh[i] - {1'b0, div_r[i]}) : sh[i][10:0];
        q_r[i]   <= {q_r[i][FRAC_W-2:0], qb[i]};
      end
    end
  end

  assign done = done_r;
  assign frac = q_r;

endmodule

// ===== rtl/psbm_sphere_ram.sv =====
// sphere table memory, one write and one registered read port
module psbm_sphere_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  psbm_pkg::sphere_t wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output psbm_pkg::sphere_t rdata,
  output logic              rvalid
);
  import psbm_pkg::*;

  sphere_t mem [DEPTH];
  sphere_t rdata_r;
  logic    rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r <= 1'b0;
    end else begin
      rvalid_r <= re;
    end
  end

  assign rdata  = rdata_r;
  assign rvalid = rvalid_r;

endmodule

// ===== rtl/psbm_isqrt.sv =====
// pipelined floor square root of a 64 bit value, one result bit per stage
module psbm_isqrt #(
  parameter int TAG_W = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [63:0]      in_val,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [31:0]      out_root,
  output logic [TAG_W-1:0] out_tag
);
  import psbm_pkg::*;

  logic [63:0]      rem_r [SQRT_STEPS];
  logic [63:0]      res_r [SQRT_STEPS];
  logic [TAG_W-1:0] tag_r [SQRT_STEPS];
  logic             vld_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0]      rem_i;
    logic [63:0]      res_i;
    logic [TAG_W-1:0] tag_i;
    logic             vld_i;
    logic [63:0]      trial;

    if (k == 0) begin : g_first
      assign rem_i = in_val;
      assign res_i = '0;
      assign tag_i = in_tag;
      assign vld_i = in_vld;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign res_i = res_r[k-1];
      assign tag_i = tag_r[k-1];
      assign vld_i = vld_r[k-1];
    end

    assign trial = res_i + BIT;

    always_ff @(posedge clk) begin
      if (rem_i >= trial) begin
        rem_r[k] <= rem_i - trial;
        res_r[k] <= (res_i >> 1) + BIT;
      end else begin
        rem_r[k] <= rem_i;
        res_r[k] <= res_i >> 1;
      end
      tag_r[k] <= tag_i;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
    end
  end

  assign out_vld  = vld_r[SQRT_STEPS-1];
  assign out_root = res_r[SQRT_STEPS-1][31:0];
  assign out_tag  = tag_r[SQRT_STEPS-1];

endmodule

// ===== rtl/psbm_dist_pipe.sv =====
// distance pipeline: minimum image, cell transform, length, less radius
module psbm_dist_pipe (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  psbm_pkg::sphere_t                sph,
  input  psbm_pkg::frac3_t                 frac,
  input  psbm_pkg::mat_t                   mat,
  output logic                             out_vld,
  output logic signed [psbm_pkg::DIST_W-1:0] out_dist
);
  import psbm_pkg::*;

  // stage a: wrapped difference
  logic                    a_vld_r;
  logic [2:0][31:0]        d_r;
  logic [RAD_W-1:0]        a_rad_r;
  // stage b: nine products, floored to Q16.32
  logic                    b_vld_r;
  logic [8:0][47:0]        p_r;
  logic [RAD_W-1:0]        b_rad_r;
  // stage c: clamped magnitudes
  logic                    c_vld_r;
  logic [2:0][31:0]        mag_r;
  logic [RAD_W-1:0]        c_rad_r;
  // stage d: squares
  logic                    d_vld_r;
  logic [2:0][63:0]        sq_r;
  logic [RAD_W-1:0]        d_rad_r;
  // stage e: sum of squares
  logic                    e_vld_r;
  logic [63:0]             sum_r;
  logic [RAD_W-1:0]        e_rad_r;
  // output
  logic                    o_vld_r;
  logic signed [DIST_W-1:0] dist_r;

  logic [8:0][63:0]        prod;
  logic [2:0][49:0]        acc;
  logic [2:0][33:0]        accs;
  logic [2:0][33:0]        mag;
  logic [2:0][31:0]        magc;
  logic                    s_vld;
  logic [31:0]             s_root;
  logic [RAD_W-1:0]        s_rad;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod[r*3+k] = 64'($signed(mat[r*3+k]) * $signed(d_r[k]));
      end
    end
    for (int r = 0; r < 3; r++) begin
      acc[r] = {{2{p_r[r*3][47]}}, p_r[r*3]} + {{2{p_r[r*3+1][47]}}, p_r[r*3+1]}
             + {{2{p_r[r*3+2][47]}}, p_r[r*3+2]};
      accs[r] = acc[r][49:16];
      mag[r]  = accs[r][33] ? 34'(~accs[r] + 34'd1) : accs[r];
      magc[r] = (mag[r] > 34'h080000000) ? 32'h80000000 : mag[r][31:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d_r[i]   <= frac[i] - (i == 0 ? sph.cx : (i == 1 ? sph.cy : sph.cz));
      mag_r[i] <= magc[i];
      sq_r[i]  <= 64'(mag_r[i]) * 64'(mag_r[i]);
    end
    for (int j = 0; j < 9; j++) begin
      p_r[j] <= prod[j][63:16];
    end
    sum_r   <= sq_r[0] + sq_r[1] + sq_r[2];
    a_rad_r <= sph.radius;
    b_rad_r <= a_rad_r;
    c_rad_r <= b_rad_r;
    d_rad_r <= c_rad_r;
    e_rad_r <= d_rad_r;
    dist_r  <= $signed({2'b00, s_root}) - $signed({3'b000, s_rad});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      o_vld_r <= s_vld;
    end
  end

  psbm_isqrt #(.TAG_W(RAD_W)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (e_vld_r),
    .in_val   (sum_r),
    .in_tag   (e_rad_r),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_tag  (s_rad)
  );

  assign out_vld  = o_vld_r;
  assign out_dist = dist_r;

endmodule

// ===== rtl/periodic_sphere_blocking_mask.sv =====
// top level of the periodic sphere blocking mask
// load items are written when accepted; a query result is valid after the fraction
// dividers, one sphere a cycle from the table memory, the distance pipeline, and the
// steps that settle the minimum, multiply the energy and register the beat
// one item is worked at a time; the next is taken once the result is registered
// synchronous active-low reset clears control and config, grid sizes to 1; tables unset
module periodic_sphere_blocking_mask #(
  parameter int MAX_SPHERES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [199:0] in_tdata,  // slot, voxel_x, voxel_y, voxel_z, center_x, center_y,
                                  // center_z, sphere_radius, matrix_value, zero pad
  input  logic [1:0]   in_tuser,  // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata, // blocking_energy
  output logic         out_tuser, // blocked
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import psbm_pkg::*;

  localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CW = $clog2(MAX_SPHERES + 1);

  // configuration
  logic [10:0]        grid_x_r, grid_y_r, grid_z_r;
  logic [8:0]         count_r;
  logic [31:0]        gain_r;
  logic signed [31:0] ceil_r;

  // fields
  op_t                op;
  logic [7:0]         slot;
  logic [2:0][9:0]    vox;
  sphere_t            wsph;
  logic [31:0]        mval;

  state_t             state_r, state_nxt;
  mat_t               mat_r;
  logic [CW-1:0]      issue_r, recv_r;
  logic               have_r;
  logic signed [DIST_W-1:0] best_r;
  logic               blk_r;
  logic [63:0]        prod_r;
  logic               out_tvalid_r;
  logic [31:0]        out_energy_r;
  logic               out_blocked_r;

  logic [2:0][10:0]   gclamp;
  logic [31:0]        n_full;
  logic [CW-1:0]      n;
  logic               accept, trivial;
  logic               rd_en, div_start, load_out;
  logic               div_done;
  frac3_t             frac;
  sphere_t            rsph;
  logic               rvld;
  logic               dist_vld;
  logic signed [DIST_W-1:0] dist_val;
  logic [31:0]        pen;
  logic [47:0]        energy;
  logic [31:0]        sat;

  assign op          = op_t'(in_tuser);
  assign slot        = in_tdata[7:0];
  assign vox[0]      = in_tdata[17:8];
  assign vox[1]      = in_tdata[27:18];
  assign vox[2]      = in_tdata[37:28];
  assign wsph.cx     = in_tdata[69:38];
  assign wsph.cy     = in_tdata[101:70];
  assign wsph.cz     = in_tdata[133:102];
  assign wsph.radius = in_tdata[164:134];
  assign mval        = in_tdata[196:165];

  always_comb begin
    gclamp[0] = (32'(grid_x_r) > 32'(MAX_GRID)) ? 11'(MAX_GRID) : grid_x_r;
    gclamp[1] = (32'(grid_y_r) > 32'(MAX_GRID)) ? 11'(MAX_GRID) : grid_y_r;
    gclamp[2] = (32'(grid_z_r) > 32'(MAX_GRID)) ? 11'(MAX_GRID) : grid_z_r;
    n_full    = (32'(count_r) > 32'(MAX_SPHERES)) ? 32'(MAX_SPHERES) : 32'(count_r);
  end

  assign n       = n_full[CW-1:0];
  assign trivial = (gclamp[0] == '0) || (gclamp[1] == '0) || (gclamp[2] == '0)
                || (n_full == '0);
  assign accept  = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && op == OP_QUERY) begin
          state_nxt = trivial ? ST_RESULT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (32'(issue_r) == n_full - 32'd1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (recv_r == n) begin
          state_nxt = ST_ENERGY;
        end
      end
      ST_ENERGY: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        div_start = in_tvalid && op == OP_QUERY && !trivial;
      end
      ST_SCAN:   rd_en = 1'b1;
      ST_RESULT: load_out = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_x_r <= 11'd1;
      grid_y_r <= 11'd1;
      grid_z_r <= 11'd1;
      count_r  <= '0;
      gain_r   <= '0;
      ceil_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_GRID_X:  grid_x_r <= cfg_data[10:0];
        REG_GRID_Y:  grid_y_r <= cfg_data[10:0];
        REG_GRID_Z:  grid_z_r <= cfg_data[10:0];
        REG_COUNT:   count_r  <= cfg_data[8:0];
        REG_GAIN:    gain_r   <= cfg_data;
        REG_CEILING: ceil_r   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_LOAD_MATRIX && 32'(slot) < 32'(MAT_ENTRIES)) begin
      mat_r[slot[3:0]] <= mval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_r      <= '0;
      recv_r       <= '0;
      have_r       <= 1'b0;
      blk_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && op == OP_QUERY) begin
        issue_r <= '0;
        recv_r  <= '0;
        have_r  <= 1'b0;
        blk_r   <= 1'b0;
      end
      if (rd_en) begin
        issue_r <= issue_r + 1'b1;
      end
      if (dist_vld) begin
        recv_r <= recv_r + 1'b1;
        have_r <= 1'b1;
      end
      if (state_r == ST_ENERGY) begin
        blk_r <= have_r && best_r[DIST_W-1];
      end
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dist_vld && (!have_r || dist_val < best_r)) begin
      best_r <= dist_val;
    end
    if (state_r == ST_ENERGY) begin
      prod_r <= 64'(pen) * 64'(gain_r);
    end
    if (load_out) begin
      out_blocked_r <= blk_r;
      out_energy_r  <= blk_r ? sat : 32'd0;
    end
  end

  assign pen    = 32'(-best_r);
  assign energy = prod_r[63:16];
  assign sat    = (ceil_r[31] || energy > {16'd0, ceil_r}) ? ceil_r : energy[31:0];

  psbm_frac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .idx   (vox),
    .grid  (gclamp),
    .done  (div_done),
    .frac  (frac)
  );

  psbm_sphere_ram #(.DEPTH(MAX_SPHERES), .AW(AW)) u_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (accept && op == OP_LOAD_SPHERE && 32'(slot) < 32'(MAX_SPHERES)),
    .waddr  (AW'(slot)),
    .wdata  (wsph),
    .re     (rd_en),
    .raddr  (issue_r[AW-1:0]),
    .rdata  (rsph),
    .rvalid (rvld)
  );

  psbm_dist_pipe u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rvld),
    .sph      (rsph),
    .frac     (frac),
    .mat      (mat_r),
    .out_vld  (dist_vld),
    .out_dist (dist_val)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_energy_r;
  assign out_tuser  = out_blocked_r;

  a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dist_vld |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("distance result outside a query scan");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_recv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> recv_r <= n)
    else $error("more distances received than spheres issued");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_tvalid && state_r == ST_IDLE)
    else $error("result load did not return to idle");

endmodule

// ===== dv/periodic_sphere_blocking_mask_tb.sv =====
// self-checking testbench of the periodic sphere blocking mask: directed table, then random phases
module periodic_sphere_blocking_mask_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psbm_pkg::*;

  localparam int NUM_SLOTS = 256;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam int SETTLE_CYCLES = 700;

  typedef struct {
    op_t         op;
    logic [7:0]  slot;
    logic [9:0]  vx, vy, vz;
    logic [31:0] cx, cy, cz;
    logic [30:0] rad;
    logic [31:0] mval;
    bit          typed;
    bit          exp_blk;
    logic [31:0] exp_energy;
  } stim_row_t;

  typedef struct {
    bit          blk;
    logic [31:0] energy;
  } mask_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [199:0] in_tdata = '0;
  logic [1:0]   in_tuser = OP_NONE;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = REG_GRID_X;
  logic [31:0]  cfg_data = '0;

  // predictor state
  logic [31:0]   sph_cx [NUM_SLOTS];
  logic [31:0]   sph_cy [NUM_SLOTS];
  logic [31:0]   sph_cz [NUM_SLOTS];
  logic [30:0]   sph_rad [NUM_SLOTS];
  longint        cell_mat [MAT_ENTRIES];
  logic [10:0]   grid [3];
  logic [8:0]    sph_count;
  logic [31:0]   gain;
  longint        ceiling;

  mask_result_t  pending_masks [$];
  stim_row_t     dir_rows [$];
  int            n_errors = 0;
  int            n_items = 0;
  int            n_results = 0;
  int            n_blocked = 0;
  bit            quiet = 1'b0;

  periodic_sphere_blocking_mask i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] rem, res, b;
    rem = v;
    res = '0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic mask_result_t predict_mask(input logic [9:0] vx, vy, vz);
    mask_result_t res;
    logic [31:0]  frac [3];
    logic [63:0]  g, num, sq_sum, mag, pen, energy;
    logic [31:0]  diff;
    logic [9:0]   idx [3];
    longint       d [3];
    longint       acc, sph_dist, best;
    int           n;
    res.blk = 1'b0;
    res.energy = '0;
    idx[0] = vx;
    idx[1] = vy;
    idx[2] = vz;
    n = (sph_count > NUM_SLOTS) ? NUM_SLOTS : sph_count;
    for (int a = 0; a < 3; a++) begin
      g = 64'((grid[a] > MAX_GRID) ? MAX_GRID : grid[a]);
      if (g == 0) return res;
      num = {22'd0, idx[a], 32'd0};
      frac[a] = 32'(num / g);
    end
    if (n == 0) return res;
    best = 0;
    for (int s = 0; s < n; s++) begin
      diff = frac[0] - sph_cx[s];
      d[0] = longint'($signed(diff));
      diff = frac[1] - sph_cy[s];
      d[1] = longint'($signed(diff));
      diff = frac[2] - sph_cz[s];
      d[2] = longint'($signed(diff));
      sq_sum = '0;
      for (int r = 0; r < 3; r++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += (cell_mat[r*3+k] * d[k]) >>> 16;
        acc = acc >>> 16;
        mag = (acc < 0) ? -acc : acc;
        if (mag > (64'd1 << 31)) mag = 64'd1 << 31;
        sq_sum += mag * mag;
      end
      sph_dist = longint'(isqrt(sq_sum)) - longint'({33'd0, sph_rad[s]});
      if (s == 0 || sph_dist < best) best = sph_dist;
    end
    if (best < 0) begin
      pen = -best;
      energy = (pen * {32'd0, gain}) >> 16;
      res.blk = 1'b1;
      res.energy = (longint'(energy) > ceiling) ? ceiling[31:0] : energy[31:0];
    end
    return res;
  endfunction

  task automatic apply_item(input stim_row_t it);
    mask_result_t res;
    case (it.op)
      OP_LOAD_SPHERE: begin
        sph_cx[it.slot] = it.cx;
        sph_cy[it.slot] = it.cy;
        sph_cz[it.slot] = it.cz;
        sph_rad[it.slot] = it.rad;
      end
      OP_LOAD_MATRIX: begin
        if (it.slot < MAT_ENTRIES) cell_mat[it.slot] = longint'($signed(it.mval));
      end
      OP_QUERY: begin
        if (it.typed) begin
          res.blk = it.exp_blk;
          res.energy = it.exp_energy;
        end else begin
          res = predict_mask(it.vx, it.vy, it.vz);
        end
        pending_masks.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input stim_row_t it);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.op;
    in_tdata <= {3'd0, it.mval, it.rad, it.cz, it.cy, it.cx, it.vz, it.vy, it.vx, it.slot};
    do @(posedge clk); while (!in_tready);
    apply_item(it);
    n_items++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRID_X:  grid[0] = val[10:0];
      REG_GRID_Y:  grid[1] = val[10:0];
      REG_GRID_Z:  grid[2] = val[10:0];
      REG_COUNT:   sph_count = val[8:0];
      REG_GAIN:    gain = val;
      REG_CEILING: ceiling = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [10:0] gx, gy, gz, input logic [8:0] cnt,
                            input logic [31:0] gn, ce);
    wait_idle();
    write_reg(REG_GRID_X, {21'd0, gx});
    write_reg(REG_GRID_Y, {21'd0, gy});
    write_reg(REG_GRID_Z, {21'd0, gz});
    write_reg(REG_COUNT, {23'd0, cnt});
    write_reg(REG_GAIN, gn);
    write_reg(REG_CEILING, ce);
  endtask

  function automatic stim_row_t blank_row(input op_t op);
    stim_row_t r;
    r.op = op;
    r.slot = 8'($urandom);
    r.vx = 10'($urandom);
    r.vy = 10'($urandom);
    r.vz = 10'($urandom);
    r.cx = $urandom;
    r.cy = $urandom;
    r.cz = $urandom;
    r.rad = 31'($urandom);
    r.mval = $urandom;
    r.typed = 1'b0;
    r.exp_blk = 1'b0;
    r.exp_energy = '0;
    return r;
  endfunction

  function automatic stim_row_t sphere_row(input logic [7:0] slot);
    stim_row_t r;
    r = blank_row(OP_LOAD_SPHERE);
    r.slot = slot;
    if ($urandom_range(0, 4) != 0) r.rad = 31'($urandom_range(0, 32'h0008_0000));
    return r;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r = blank_row(OP_QUERY);
    end else if (pick < 80) begin
      r = sphere_row(8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 255)));
    end else if (pick < 92) begin
      r = blank_row(OP_LOAD_MATRIX);
      if ($urandom_range(0, 4) != 0) r.slot = 8'($urandom_range(0, MAT_ENTRIES - 1));
      if ($urandom_range(0, 9) < 7) begin
        if (r.slot % 4 == 0) r.mval = $urandom_range(32'h0005_0000, 32'h0028_0000);
        else r.mval = $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
      end
    end else begin
      r = blank_row(OP_NONE);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    int stall;
    if (stall > 0) begin
      stall--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall = $urandom_range(1, 14) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    mask_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_masks.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat blocked=%0b energy=%h",
                                  out_tuser, out_tdata));
      end else begin
        want = pending_masks.pop_front();
        n_results++;
        if (want.blk) n_blocked++;
        if (out_tuser !== want.blk)
          report_mismatch($sformatf("blocked %b, want %b", out_tuser, want.blk));
        if (out_tdata !== want.energy)
          report_mismatch($sformatf("energy %h, want %h", out_tdata, want.energy));
      end
    end
  end

  initial begin
    stim_row_t r;
    int guard;
    grid[0] = 11'd1;
    grid[1] = 11'd1;
    grid[2] = 11'd1;
    sph_count = '0;
    gain = '0;
    ceiling = 0;
    for (int i = 0; i < MAT_ENTRIES; i++) cell_mat[i] = 0;

    // directed table, sphere count is zero at reset so queries answer zero
    r = blank_row(OP_QUERY);
    r.vx = '0; r.vy = '0; r.vz = '0; r.typed = 1'b1;
    dir_rows.push_back(r);
    r.vx = '1; r.vy = '1; r.vz = '1;
    dir_rows.push_back(r);
    dir_rows.push_back(blank_row(OP_NONE));
    r = blank_row(OP_LOAD_MATRIX);
    r.slot = 8'hff;
    dir_rows.push_back(r);
    r.slot = 8'd9;
    dir_rows.push_back(r);
    for (int i = 0; i < MAT_ENTRIES; i++) begin
      r = blank_row(OP_LOAD_MATRIX);
      r.slot = 8'(i);
      case (i)
        0: r.mval = 32'h0014_0000;
        1: r.mval = 32'h7fff_ffff;
        4: r.mval = 32'h0019_0000;
        5: r.mval = 32'h8000_0000;
        8: r.mval = 32'h001e_0000;
        default: r.mval = '0;
      endcase
      dir_rows.push_back(r);
    end
    r = blank_row(OP_LOAD_SPHERE);
    r.slot = 8'd0; r.cx = '0; r.cy = '0; r.cz = '0; r.rad = '1;
    dir_rows.push_back(r);
    r.slot = 8'hff; r.cx = '1; r.cy = '1; r.cz = '1; r.rad = '0;
    dir_rows.push_back(r);
    r = blank_row(OP_QUERY);
    r.vx = 10'd512; r.vy = '0; r.vz = '1; r.typed = 1'b1;
    dir_rows.push_back(r);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i]);
    for (int s = 1; s < NUM_SLOTS - 1; s++) send_item(sphere_row(8'(s)));

    wait_idle();
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    set_config(11'd1024, 11'd1024, 11'd1024, 9'd256, 32'hffff_ffff, 32'h7fff_ffff);
    repeat (40) send_item(random_row());
    set_config(11'd2047, 11'd0, 11'd5, 9'd511, 32'h0001_0000, 32'h8000_0000);
    repeat (15) send_item(random_row());
    set_config(11'd2047, 11'd3, 11'd7, 9'd4, 32'h0001_0000, 32'h8000_0000);
    repeat (60) send_item(random_row());
    set_config(11'd1, 11'd1, 11'd1, 9'd1, 32'h0000_0000, 32'h0000_0000);
    repeat (40) send_item(random_row());

    for (int ph = 0; ph < 10; ph++) begin
      set_config($urandom_range(0, 19) == 0 ? 11'($urandom) : 11'($urandom_range(1, 1024)),
                 11'($urandom_range(1, 1024)), 11'($urandom_range(1, 64)),
                 $urandom_range(0, 9) == 0 ? 9'($urandom_range(200, 511))
                                           : 9'($urandom_range(1, 16)),
                 $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0010_0000),
                 $urandom);
      if (ph == 9) quiet = 1'b1;
      repeat (150) send_item(random_row());
    end

    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_masks.size() != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_masks.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_masks.size()));

    $display("run covered %0d items, %0d query results, %0d of them blocked",
             n_items, n_results, n_blocked);
    $display("settings swept: grid extremes, zero and saturated sizes and counts, gain/ceiling");
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
